[src/frp_pkg.sv]
// Shared types and constants of the FASTQ record parser.
package frp_pkg;

	localparam int MAX_LINE_LEN = 65535;
	localparam int CNT_W = 16;
	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	localparam logic [7:0] RECORD_MARK = 8'h40;
	localparam logic [7:0] SCORE_OFFSET_RESET = 8'd33;

	typedef enum logic [2:0] {
		KIND_NAME  = 3'd0,
		KIND_SEQ   = 3'd1,
		KIND_SCORE = 3'd2,
		KIND_END   = 3'd3,
		KIND_ERROR = 3'd4
	} frp_kind_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NOT_FASTQ = 3'd1,
		ST_NO_NAME   = 3'd2,
		ST_NO_SEQ    = 3'd3,
		ST_NO_SCORES = 3'd4,
		ST_MISMATCH  = 3'd5,
		ST_TOO_LONG  = 3'd6
	} frp_status_t;

	typedef struct packed {
		frp_kind_t   kind;
		logic [7:0]  data;
		frp_status_t status;
	} frp_entry_t;

endpackage

[src/frp_front.sv]
// Front end: record phase tracking, line counters and result classification.
module frp_front import frp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] text_byte,
	input  logic       q_full,
	output logic       push,
	output frp_entry_t push_entry
);

	typedef enum logic [2:0] {
		PH_SEEK,
		PH_NAME,
		PH_SEQ,
		PH_COMMENT,
		PH_SCORE
	} phase_t;

	localparam logic [CNT_W-1:0] LIMIT = CNT_W'(MAX_LINE_LEN);

	phase_t           phase_q, phase_d;
	logic [CNT_W-1:0] name_cnt_q, name_cnt_d;
	logic [CNT_W-1:0] seq_cnt_q, seq_cnt_d;
	logic [CNT_W-1:0] score_cnt_q, score_cnt_d;
	logic             accept;
	logic             eol;
	logic             letter;

	assign in_ready = !q_full;
	assign accept = in_valid && in_ready;
	assign eol = (text_byte == 8'h0A) || (text_byte == 8'h00);
	assign letter = ((text_byte >= 8'h41) && (text_byte <= 8'h5A)) ||
			((text_byte >= 8'h61) && (text_byte <= 8'h7A));

	always_comb begin
		logic fail;
		frp_status_t fail_st;
		fail = 1'b0;
		fail_st = ST_OK;
		phase_d = phase_q;
		name_cnt_d = name_cnt_q;
		seq_cnt_d = seq_cnt_q;
		score_cnt_d = score_cnt_q;
		push = 1'b0;
		push_entry.kind = KIND_NAME;
		push_entry.data = text_byte;
		push_entry.status = ST_OK;
		case (phase_q)
			PH_SEEK: begin
				if (text_byte == RECORD_MARK) begin
					phase_d = PH_NAME;
				end else if (letter) begin
					fail = 1'b1;
					fail_st = ST_NOT_FASTQ;
				end
			end
			PH_NAME: begin
				if (eol) begin
					if (name_cnt_q == '0) begin
						fail = 1'b1;
						fail_st = ST_NO_NAME;
					end else begin
						phase_d = PH_SEQ;
					end
				end else if (name_cnt_q >= LIMIT) begin
					fail = 1'b1;
					fail_st = ST_TOO_LONG;
				end else begin
					name_cnt_d = name_cnt_q + 1'b1;
					push = 1'b1;
					push_entry.kind = KIND_NAME;
				end
			end
			PH_SEQ: begin
				if (eol) begin
					if (seq_cnt_q == '0) begin
						fail = 1'b1;
						fail_st = ST_NO_SEQ;
					end else begin
						phase_d = PH_COMMENT;
					end
				end else if (seq_cnt_q >= LIMIT) begin
					fail = 1'b1;
					fail_st = ST_TOO_LONG;
				end else begin
					seq_cnt_d = seq_cnt_q + 1'b1;
					push = 1'b1;
					push_entry.kind = KIND_SEQ;
				end
			end
			PH_COMMENT: begin
				if (eol) begin
					phase_d = PH_SCORE;
				end
			end
			PH_SCORE: begin
				if (eol) begin
					if (score_cnt_q == '0) begin
						fail = 1'b1;
						fail_st = ST_NO_SCORES;
					end else if (score_cnt_q != seq_cnt_q) begin
						fail = 1'b1;
						fail_st = ST_MISMATCH;
					end else begin
						// record end: back to seeking
						phase_d = PH_SEEK;
						name_cnt_d = '0;
						seq_cnt_d = '0;
						score_cnt_d = '0;
						push = 1'b1;
						push_entry.kind = KIND_END;
						push_entry.data = 8'h00;
					end
				end else if (score_cnt_q >= LIMIT) begin
					fail = 1'b1;
					fail_st = ST_TOO_LONG;
				end else begin
					score_cnt_d = score_cnt_q + 1'b1;
					push = 1'b1;
					push_entry.kind = KIND_SCORE;
				end
			end
			default: begin
				phase_d = PH_SEEK;
				name_cnt_d = '0;
				seq_cnt_d = '0;
				score_cnt_d = '0;
			end
		endcase
		if (fail) begin
			phase_d = PH_SEEK;
			name_cnt_d = '0;
			seq_cnt_d = '0;
			score_cnt_d = '0;
			push = 1'b1;
			push_entry.kind = KIND_ERROR;
			push_entry.data = 8'h00;
			push_entry.status = fail_st;
		end
		push = push && accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEEK;
			name_cnt_q <= '0;
			seq_cnt_q <= '0;
			score_cnt_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			name_cnt_q <= name_cnt_d;
			seq_cnt_q <= seq_cnt_d;
			score_cnt_q <= score_cnt_d;
		end
	end

endmodule

[src/frp_queue.sv]
// Short result queue between the front end and the output stage.
module frp_queue import frp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  frp_entry_t push_entry,
	output logic       full,
	input  logic       pop,
	output logic       q_valid,
	output frp_entry_t head_entry
);

	frp_entry_t     slot_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;

	assign full = (count_q == (QAW+1)'(QDEPTH));
	assign q_valid = (count_q != '0);
	assign head_entry = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[src/frp_back.sv]
// Back end: score conversion, offset register and output register.
module frp_back import frp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data,
	input  logic       q_valid,
	input  frp_entry_t head_entry,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] item_kind,
	output logic [7:0] data_byte,
	output logic [2:0] status
);

	logic [7:0] score_offset_q;
	logic       out_valid_q;
	frp_entry_t out_q;
	logic [7:0] conv_byte;

	assign cfg_ready = 1'b1;
	assign pop = q_valid && (!out_valid_q || out_ready);
	assign conv_byte = (head_entry.kind == KIND_SCORE) ?
			(head_entry.data - score_offset_q) : head_entry.data;

	assign out_valid = out_valid_q;
	assign item_kind = out_q.kind;
	assign data_byte = out_q.data;
	assign status = out_q.status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_offset_q <= SCORE_OFFSET_RESET;
		end else if (cfg_valid && cfg_ready) begin
			score_offset_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// load the next transaction whenever the register is free or drained
	always_ff @(posedge clk) begin
		if (pop) begin
			out_q.kind <= head_entry.kind;
			out_q.data <= conv_byte;
			out_q.status <= head_entry.status;
		end
	end

endmodule

[src/fastq_record_parser.sv]
// FASTQ record parser top level: front end, result queue and output stage.
// Throughput: one text byte per cycle while the result queue is not full (in_ready is low when it is full).
// A result passes through a queue slot write, then the output register load, before it shows
// on the output; bytes without a result leave nothing.
// A four-entry queue lets the front keep accepting while the output is stalled.
// Reset: seeking '@', counters zero, queue and output empty, score_offset 33.
module fastq_record_parser import frp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] text_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] item_kind,
	output logic [7:0] data_byte,
	output logic [2:0] status
);

	logic       push;
	frp_entry_t push_entry;
	logic       q_full;
	logic       pop;
	logic       q_valid;
	frp_entry_t head_entry;

	frp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.text_byte  (text_byte),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	frp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.q_valid    (q_valid),
		.head_entry (head_entry)
	);

	frp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.q_valid    (q_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.item_kind  (item_kind),
		.data_byte  (data_byte),
		.status     (status)
	);

endmodule
